/* rtl/a85_pkg.sv */
package a85_pkg;

    localparam int unsigned CMD_DEPTH = 4;

    localparam logic [7:0] CHAR_BANG  = 8'h21;  // digit zero
    localparam logic [7:0] CHAR_U     = 8'h75;  // digit 84
    localparam logic [7:0] CHAR_Z     = 8'h7A;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic [19:0] RADIX = 20'd85;

    typedef enum logic [2:0] {
        KIND_DATA       = 3'd0,
        KIND_DONE       = 3'd1,
        KIND_BAD_CHAR   = 3'd2,
        KIND_BAD_Z      = 3'd3,
        KIND_LONE_DIGIT = 3'd4
    } kind_t;

    typedef enum logic {
        PHASE_ACTIVE = 1'b0,
        PHASE_HALTED = 1'b1
    } phase_t;

    // One decoded transaction's worth of results: up to four bytes of word,
    // most significant first, then an optional closing code.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  nbytes;
        logic        has_tail;
        kind_t       tail_kind;
    } cmd_t;

    // Padding a group of cnt digits with 'u' digits: v * 85^k + (85^k - 1),
    // with k = 5 - cnt.
    function automatic logic [19:0] pad_mult(input logic [2:0] cnt);
        logic [19:0] m;
        case (cnt)
            3'd2:    m = 20'd614125;
            3'd3:    m = 20'd7225;
            default: m = 20'd85;
        endcase
        return m;
    endfunction

    function automatic logic [19:0] pad_add(input logic [2:0] cnt);
        logic [19:0] a;
        case (cnt)
            3'd2:    a = 20'd614124;
            3'd3:    a = 20'd7224;
            default: a = 20'd84;
        endcase
        return a;
    endfunction

endpackage

/* rtl/a85_front.sv */
module a85_front
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] in_char,
    input  logic       end_of_buffer,
    output logic       cmd_push,
    output cmd_t       cmd
);

    logic [31:0] acc_reg, acc_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        tilde_reg, tilde_next;
    phase_t      phase_reg, phase_next;

    logic [19:0] mult_k;
    logic [19:0] addend;
    logic [31:0] prod;
    logic        is_space;

    // One multiplier serves both the digit step and the end-marker padding.
    assign mult_k   = tilde_reg ? pad_mult(cnt_reg) : RADIX;
    assign addend   = tilde_reg ? pad_add(cnt_reg) : {12'd0, in_char - CHAR_BANG};
    assign prod     = 32'(acc_reg * {12'd0, mult_k}) + {12'd0, addend};
    assign is_space = (in_char == CHAR_SPACE) || (in_char inside {[CHAR_TAB:CHAR_CR]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            tilde_reg <= 1'b0;
            phase_reg <= PHASE_ACTIVE;
        end
        else
        begin
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            tilde_reg <= tilde_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        acc_next      = acc_reg;
        cnt_next      = cnt_reg;
        tilde_next    = tilde_reg;
        phase_next    = phase_reg;
        cmd.word      = '0;
        cmd.nbytes    = '0;
        cmd.has_tail  = 1'b0;
        cmd.tail_kind = KIND_DATA;

        if (accept && phase_reg == PHASE_ACTIVE)
        begin
            if (tilde_reg)
            begin
                tilde_next = 1'b0;
                if (in_char == CHAR_GT)
                begin
                    cmd.has_tail = 1'b1;
                    if (cnt_reg == 3'd1)
                    begin
                        cmd.tail_kind = KIND_LONE_DIGIT;
                    end
                    else
                    begin
                        cmd.tail_kind = KIND_DONE;
                        if (cnt_reg >= 3'd2)
                        begin
                            cmd.word   = prod;
                            cmd.nbytes = cnt_reg - 3'd1;
                        end
                    end
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = PHASE_HALTED;
                end
                else
                begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_kind = KIND_BAD_CHAR;
                    phase_next    = PHASE_HALTED;
                end
            end
            else if (in_char inside {[CHAR_BANG:CHAR_U]})
            begin
                if (cnt_reg == 3'd4)
                begin
                    cmd.word   = prod;
                    cmd.nbytes = 3'd4;
                    acc_next   = '0;
                    cnt_next   = '0;
                end
                else
                begin
                    acc_next = prod;
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            else if (in_char == CHAR_Z)
            begin
                if (cnt_reg != 3'd0)
                begin
                    cmd.has_tail  = 1'b1;
                    cmd.tail_kind = KIND_BAD_Z;
                    phase_next    = PHASE_HALTED;
                end
                else
                begin
                    cmd.nbytes = 3'd4;
                end
            end
            else if (in_char == CHAR_TILDE)
            begin
                tilde_next = 1'b1;
            end
            else if (!is_space)
            begin
                cmd.has_tail  = 1'b1;
                cmd.tail_kind = KIND_BAD_CHAR;
                phase_next    = PHASE_HALTED;
            end

            // close a stream that is still running at its last character
            if (end_of_buffer && phase_next == PHASE_ACTIVE)
            begin
                cmd.has_tail  = 1'b1;
                cmd.tail_kind = tilde_next ? KIND_BAD_CHAR : KIND_DONE;
            end
        end

        if (accept && end_of_buffer)
        begin
            acc_next   = '0;
            cnt_next   = '0;
            tilde_next = 1'b0;
            phase_next = PHASE_ACTIVE;
        end
    end

    assign cmd_push = accept && (cmd.nbytes != 3'd0 || cmd.has_tail);

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 3'd4)
        else $error("digit count out of range");

    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PHASE_HALTED) |-> !cmd_push)
        else $error("halted stream produced a result");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_buffer) |=> (cnt_reg == 3'd0 && !tilde_reg
                                       && phase_reg == PHASE_ACTIVE))
        else $error("state not cleared after last character");

endmodule

/* rtl/a85_cmd_fifo.sv */
module a85_cmd_fifo
    import a85_pkg::*;
#(
    parameter int unsigned DEPTH = CMD_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic not_empty,
    output logic full
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign not_empty = count_reg != '0;
    assign full      = count_reg == CNT_W'(DEPTH);
    assign rd_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !full)
        else $error("command written into full queue");

endmodule

/* rtl/a85_back.sv */
module a85_back
    import a85_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  cmd_t       head,
    output logic       head_pop,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       last_of_run
);

    logic [2:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    kind_t      kind_reg, kind_next;
    logic       last_reg, last_next;
    logic       load;
    logic [2:0] total;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = head_valid && (!valid_reg || pop);
    assign total   = head.nbytes + {2'd0, head.has_tail};
    assign is_last = idx_reg == (total - 3'd1);

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    sel_byte = head.word[31:24];
            2'd1:    sel_byte = head.word[23:16];
            2'd2:    sel_byte = head.word[15:8];
            default: sel_byte = head.word[7:0];
        endcase
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        kind_next  = kind_reg;
        last_next  = last_reg;
        head_pop   = 1'b0;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = is_last;
            if (idx_reg < head.nbytes)
            begin
                byte_next = sel_byte;
                kind_next = KIND_DATA;
            end
            else
            begin
                byte_next = '0;
                kind_next = head.tail_kind;
            end
            // advance through the transaction, release it on its final result
            if (is_last)
            begin
                idx_next = '0;
                head_pop = 1'b1;
            end
            else
            begin
                idx_next = idx_reg + 3'd1;
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        kind_reg <= kind_next;
        last_reg <= last_next;
    end

    assign empty       = !valid_reg;
    assign out_byte    = byte_reg;
    assign kind        = kind_reg;
    assign last_of_run = last_reg;

    a_code_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && kind_reg != KIND_DATA) |-> (byte_reg == 8'd0 && last_reg))
        else $error("closing code carries data or is not final");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg < total))
        else $error("result index past end of transaction");

endmodule

/* rtl/ascii85_stream_decoder.sv */
// ASCII85 stream decoder. One character enters per cycle (push while full is
// low); results leave one per cycle while popped, through a queue-style port
// (pop while empty is low). A character is decoded in the cycle it is accepted
// and becomes one transaction of zero to five results in a command queue of
// CMD_DEPTH entries; the output stage expands each transaction one result a
// cycle while pop is high, so a fifth digit or a 'z' yields four results (five
// when it also ends the stream). Full rises only when that queue is backed up;
// with pop held high, a stream of plain groups (five characters in, four bytes
// out) runs at one character per cycle indefinitely. The final result of each
// transaction carries last_of_run. The decode path holds a single 32x20
// multiplier shared by the digit step and the end-marker padding.
module ascii85_stream_decoder
    import a85_pkg::*;
#(
    parameter int unsigned CMD_DEPTH_P = CMD_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_char,
    input  logic       end_of_buffer,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic [2:0] kind,
    output logic       last_of_run
);

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    cmd_t head;
    logic head_valid;
    logic head_pop;

    assign accept = push && !full;

    a85_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_char       (in_char),
        .end_of_buffer (end_of_buffer),
        .cmd_push      (cmd_push),
        .cmd           (cmd)
    );

    a85_cmd_fifo #(
        .DEPTH (CMD_DEPTH_P)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cmd_push),
        .wr_data   (cmd),
        .rd_en     (head_pop),
        .rd_data   (head),
        .not_empty (head_valid),
        .full      (full)
    );

    a85_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head        (head),
        .head_pop    (head_pop),
        .pop         (pop),
        .empty       (empty),
        .out_byte    (out_byte),
        .kind        (kind),
        .last_of_run (last_of_run)
    );

endmodule
